// File: hdl/itrd_pkg.sv
// Shared types, constants and the digit character function for the radix digit converter.
package itrd_pkg;

  localparam int VALUE_PORT_W    = 64;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int STEP_BITS       = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A_BASE = 7'd87;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } itrd_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A_BASE + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: hdl/integer_to_radix_digits_top.sv
// Top level of the converter from an unsigned integer to ASCII digits in a set radix.
//
// The input channel (in_valid, in_stall, in_value) takes one unsigned number per
// transaction; only the low VALUE_WIDTH bits are used. The output channel (out_valid,
// out_stall, out_digit_char, out_last_digit) returns its digits, most significant first,
// as ASCII '0'-'9' and 'a'-'z', one per transaction; out_last_digit marks the final one.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the radix; values
// below 2 act as 2 and values above 36 act as 36. Write it only while the block is idle.
// Each digit is found by a shared divider that handles STEP_BITS dividend bits a cycle.
// Digits go into a small memory and are read back in reverse order, each one passing
// through a read state and then a show state.
// The block takes no new item until the last digit of the current one is delivered.
// While out_stall is high the shown digit holds and the sequencer waits.
// Reset sets the radix to 10 and returns the sequencer to idle; nothing else is kept.
module integer_to_radix_digits_top #(
  parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [itrd_pkg::VALUE_PORT_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [itrd_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0]       cfg_data
);
  import itrd_pkg::*;

  localparam int ITER  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int QW    = ITER * STEP_BITS;
  localparam int SW    = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int DEPTH = VALUE_WIDTH;

  itrd_state_t state_r, state_nxt;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base_r, base_nxt;
  logic [QW-1:0]      q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [DIGIT_W-1:0] mem [DEPTH];

  logic [DIGIT_W-1:0] div_rem;
  logic [QW-1:0]      div_q;
  logic               last_step;
  logic               div_done;
  logic               wr_en;
  logic               rd_en;
  logic [RADIX_W-1:0] radix_eff;

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  always_comb begin
    logic [DIGIT_W-1:0]   r;
    logic [DIGIT_W:0]     t;
    logic [STEP_BITS-1:0] chunk;
    logic [STEP_BITS-1:0] qb;
    r     = rem_r;
    chunk = q_r[QW-1 -: STEP_BITS];
    qb    = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= {1'b0, base_r}) begin
        t     = t - {1'b0, base_r};
        qb[i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    div_rem = r;
    div_q   = (q_r << STEP_BITS) | QW'(qb);
  end

  assign last_step = (step_r == SW'(ITER - 1));
  assign div_done  = (state_r == ST_DIV) && last_step && (div_q == '0);
  assign wr_en     = (state_r == ST_DIV) && last_step;
  assign rd_en     = (state_r == ST_READ);

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    ptr_nxt  = ptr_r;
    base_nxt = base_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          q_nxt    = QW'(in_value[VALUE_WIDTH-1:0]);
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
          base_nxt = radix_eff;
        end
      end
      ST_DIV: begin
        q_nxt    = div_q;
        rem_nxt  = div_rem;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          rem_nxt  = '0;
          step_nxt = '0;
          if (div_q == '0) begin
            ptr_nxt = cnt_r;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_SHOW: begin
        if (!out_stall && (ptr_r != '0)) begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall) begin
          state_nxt = (ptr_r == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_digit_char = digit_to_char(rd_data_r);
  assign out_last_digit = (ptr_r == '0);
  assign cfg_ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radix_r <= RADIX_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    ptr_r  <= ptr_nxt;
    base_r <= base_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r] <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit && !out_stall |=> !out_valid && !in_stall)
    else $error("block did not return to idle after the last digit");

  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (base_r >= RADIX_MIN) && (base_r <= RADIX_MAX))
    else $error("divisor outside the supported radix range");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < base_r))
    else $error("partial remainder not below the divisor");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input accepted while a digit is still shown");

endmodule

// File: sim/tb_integer_to_radix_digits_top.sv
// Self-checking testbench for the integer to radix digit converter top level.
module tb_integer_to_radix_digits_top;
  import itrd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last_flag;
  } digit_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [VALUE_PORT_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [CHAR_W-1:0]       out_digit_char;
  logic                    out_last_digit;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [RADIX_W-1:0]      cfg_data;

  string              digit_glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
  logic [RADIX_W-1:0] radix_shadow;
  digit_t             pending_digits[$];
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 hold_left;
  int                 errors;
  int                 numbers_sent;
  int                 digits_checked;
  int                 radix_writes;

  integer_to_radix_digits_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_last_digit(out_last_digit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Timed out with %0d digits still outstanding.", pending_digits.size());
    $display("TEST FAILED");
    $finish;
  end

  // Expected digits of a number in the current radix, most significant first.
  function automatic void predict_digits(input logic [VALUE_PORT_W-1:0] number);
    logic [VALUE_PORT_W-1:0] rest;
    logic [RADIX_W-1:0]      base;
    logic [DIGIT_W-1:0]      reversed[$];
    digit_t                  entry;
    int                      k;
    base = radix_shadow;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    rest = number;
    if (rest == '0) begin
      reversed = {reversed, DIGIT_W'(0)};
    end
    while (rest != '0) begin
      reversed = {reversed, DIGIT_W'(rest % base)};
      rest = rest / base;
    end
    for (k = reversed.size() - 1; k >= 0; k--) begin
      entry.ch = CHAR_W'(digit_glyphs[reversed[k]]);
      entry.last_flag = (k == 0);
      pending_digits = {pending_digits, entry};
    end
  endfunction

  // The receiver either sits out a long hold or stalls at random.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_digits
    digit_t expected;
    if (rst_n && out_valid && !out_stall) begin
      digits_checked++;
      if (pending_digits.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                 $time, out_digit_char, out_last_digit);
      end else begin
        expected = pending_digits.pop_front();
        if (out_digit_char !== expected.ch) begin
          errors++;
          $display("%0t: digit char mismatch: expected %0d, actual %0d",
                   $time, expected.ch, out_digit_char);
        end
        if (out_last_digit !== expected.last_flag) begin
          errors++;
          $display("%0t: last digit flag mismatch: expected %0b, actual %0b",
                   $time, expected.last_flag, out_last_digit);
        end
      end
    end
  end

  task automatic send_number(input logic [VALUE_PORT_W-1:0] number);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= number;
    do @(posedge clk); while (in_stall);
    predict_digits(number);
    numbers_sent++;
  endtask

  task automatic finish_batch();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] setting);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_shadow = setting;
    radix_writes++;
  endtask

  function automatic logic [VALUE_PORT_W-1:0] random_number();
    logic [VALUE_PORT_W-1:0] number;
    case ($urandom_range(0, 3))
      0: number = {$urandom(), $urandom()};
      1: number = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      2: number = VALUE_PORT_W'($urandom_range(0, 100));
      default: number = (64'd1 << $urandom_range(0, 63)) - VALUE_PORT_W'($urandom_range(0, 1));
    endcase
    return number;
  endfunction

  task automatic test_decimal_after_reset();
    send_number(64'd0);
    send_number(64'd1);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd1234567890);
    send_number(64'h7FFF_FFFF_FFFF_FFFF);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    finish_batch();
  endtask

  task automatic test_radix_extremes();
    write_radix(RADIX_MIN);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'd1);
    finish_batch();
    write_radix(RADIX_MAX);
    send_number(64'd35);
    send_number(64'd36);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    finish_batch();
    write_radix(6'd0);
    send_number(64'h8000_0000_0000_0000);
    finish_batch();
    write_radix(6'd1);
    send_number(64'd5);
    finish_batch();
    write_radix(6'd63);
    send_number(64'd35);
    finish_batch();
    write_radix(6'd37);
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    finish_batch();
    write_radix(6'd16);
    send_number(64'h0123_4567_89AB_CDEF);
    finish_batch();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      if (n % 8 == 0) begin
        finish_batch();
        case ($urandom_range(0, 5))
          0: write_radix(6'd0);
          1: write_radix(6'd63);
          2: write_radix(RADIX_MIN);
          3: write_radix(RADIX_MAX);
          default: write_radix(RADIX_W'($urandom_range(0, 63)));
        endcase
      end
      send_number(random_number());
    end
    finish_batch();
  endtask

  task automatic test_receiver_hold();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_radix(RADIX_RESET);
    hold_left = 400;
    for (n = 0; n < 12; n++) begin
      send_number({$urandom(), $urandom()});
    end
    finish_batch();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value       = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    radix_shadow   = RADIX_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    errors         = 0;
    numbers_sent   = 0;
    digits_checked = 0;
    radix_writes   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decimal_after_reset();
    test_radix_extremes();
    test_random_traffic(0, 0, 32);
    test_random_traffic(88, 0, 32);
    test_random_traffic(0, 88, 32);
    test_random_traffic(29, 29, 32);
    test_receiver_hold();

    repeat (700) @(posedge clk);
    $display("Converted %0d numbers into %0d checked digits across %0d radix writes,",
             numbers_sent, digits_checked, radix_writes);
    $display("including clamped radix settings, full-width values and a long receiver hold.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
